// ----- rtl/core/gemm_pkg.sv -----
// Shared types, widths, codes and saturation helpers of the 4x4 tile accumulator.
`default_nettype none
package gemm_pkg;

   localparam int DATA_W  = 16;
   localparam int ACC_W   = 48;
   localparam int FIELD_W = 48;
   localparam int B_W     = 16;
   localparam int TILE_N  = 4;
   localparam int ROW_W   = $clog2(TILE_N);
   localparam int PROD_W  = 2 * DATA_W;

   // Wide enough for a sum of an accumulator and a product, and for a loaded C value.
   localparam int WIDE_BASE = (ACC_W > PROD_W) ? ACC_W : PROD_W;
   localparam int WIDE_W    = ((WIDE_BASE > FIELD_W) ? WIDE_BASE : FIELD_W) + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [WIDE_W-1:0] ACC_MAX =
      {{(WIDE_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] ACC_MIN = ~ACC_MAX;
   localparam logic signed [WIDE_W-1:0] FIELD_MAX =
      {{(WIDE_W - FIELD_W + 1){1'b0}}, {(FIELD_W - 1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] FIELD_MIN = ~FIELD_MAX;

   localparam logic CMD_LOAD       = 1'b0;
   localparam logic CMD_ACCUMULATE = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ACC,
      OP_ACC_LAST
   } op_type;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic signed [B_W-1:0]     bval_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef struct packed {
      op_type                     op;
      logic [ROW_W-1:0]           row;
      logic [TILE_N-1:0][FIELD_W-1:0] x;
      logic [TILE_N-1:0][B_W-1:0]     b;
   } item_type;

   function automatic acc_type clamp_acc(input logic signed [WIDE_W-1:0] v);
      acc_type r;
      if (v > ACC_MAX) begin
         r = ACC_MAX[ACC_W-1:0];
      end else if (v < ACC_MIN) begin
         r = ACC_MIN[ACC_W-1:0];
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic field_type clamp_field(input logic signed [WIDE_W-1:0] v);
      field_type r;
      if (v > FIELD_MAX) begin
         r = FIELD_MAX[FIELD_W-1:0];
      end else if (v < FIELD_MIN) begin
         r = FIELD_MIN[FIELD_W-1:0];
      end else begin
         r = v[FIELD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gemm_if.sv -----
// Valid/ready channel interfaces for request words and tile-row result words.
`default_nettype none
interface gemm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [gemm_pkg::ROW_W-1:0]  row;
   logic signed [gemm_pkg::FIELD_W-1:0] x0;
   logic signed [gemm_pkg::FIELD_W-1:0] x1;
   logic signed [gemm_pkg::FIELD_W-1:0] x2;
   logic signed [gemm_pkg::FIELD_W-1:0] x3;
   logic signed [gemm_pkg::B_W-1:0]     b0;
   logic signed [gemm_pkg::B_W-1:0]     b1;
   logic signed [gemm_pkg::B_W-1:0]     b2;
   logic signed [gemm_pkg::B_W-1:0]     b3;
   logic                        last_k;

   modport source (output valid, command, row, x0, x1, x2, x3, b0, b1, b2, b3, last_k,
                   input ready);
   modport sink (input valid, command, row, x0, x1, x2, x3, b0, b1, b2, b3, last_k,
                 output ready);
endinterface

interface gemm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gemm_pkg::ROW_W-1:0]  out_row;
   logic signed [gemm_pkg::FIELD_W-1:0] sum0;
   logic signed [gemm_pkg::FIELD_W-1:0] sum1;
   logic signed [gemm_pkg::FIELD_W-1:0] sum2;
   logic signed [gemm_pkg::FIELD_W-1:0] sum3;
   logic                        last_row;

   modport source (output valid, out_row, sum0, sum1, sum2, sum3, last_row, input ready);
   modport sink (input valid, out_row, sum0, sum1, sum2, sum3, last_row, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gemm_front.sv -----
// Front end: takes request words and classifies them into queue entries.
`default_nettype none
module gemm_front (
   gemm_req_if.sink            req_ch,
   input  wire logic           queue_full,
   output logic                push,
   output gemm_pkg::item_type  push_item
);

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      push_item.row  = req_ch.row;
      push_item.x[0] = req_ch.x0;
      push_item.x[1] = req_ch.x1;
      push_item.x[2] = req_ch.x2;
      push_item.x[3] = req_ch.x3;
      push_item.b[0] = req_ch.b0;
      push_item.b[1] = req_ch.b1;
      push_item.b[2] = req_ch.b2;
      push_item.b[3] = req_ch.b3;
      unique case (req_ch.command)
         gemm_pkg::CMD_LOAD: begin
            push_item.op = gemm_pkg::OP_LOAD;
         end
         gemm_pkg::CMD_ACCUMULATE: begin
            push_item.op = req_ch.last_k ? gemm_pkg::OP_ACC_LAST : gemm_pkg::OP_ACC;
         end
         default: begin
            push_item.op = gemm_pkg::OP_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/core/gemm_queue.sv -----
// Short FIFO of classified words between the front end and the back end.
`default_nettype none
module gemm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire gemm_pkg::item_type  push_item,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output gemm_pkg::item_type       pop_item
);

   gemm_pkg::item_type entry_ff [gemm_pkg::QUEUE_DEPTH];

   logic [gemm_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [gemm_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [gemm_pkg::QCOUNT_W-1:0] count_ff, count_in;

   function automatic logic [gemm_pkg::QPTR_W-1:0] next_ptr(
         input logic [gemm_pkg::QPTR_W-1:0] p);
      logic [gemm_pkg::QPTR_W-1:0] r;
      if (p == gemm_pkg::QPTR_W'(gemm_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + gemm_pkg::QPTR_W'(1);
      end
      return r;
   endfunction

   assign full      = (count_ff == gemm_pkg::QCOUNT_W'(gemm_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + gemm_pkg::QCOUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - gemm_pkg::QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= gemm_pkg::QCOUNT_W'(gemm_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/gemm_back.sv -----
// Back end: multiply stage, saturating accumulate stage and tile-row emitter.
`default_nettype none
module gemm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                queue_not_empty,
   input  wire gemm_pkg::item_type  queue_item,
   output logic                     pop,
   gemm_rsp_if.source               rsp_ch
);

   localparam int N = gemm_pkg::TILE_N;

   // Multiply stage registers.
   logic                         m_valid_ff, m_valid_in;
   gemm_pkg::op_type             m_op_ff, m_op_in;
   logic [gemm_pkg::ROW_W-1:0]   m_row_ff, m_row_in;
   gemm_pkg::prod_type           m_prod_ff [N][N];
   gemm_pkg::prod_type           m_prod_in [N][N];
   gemm_pkg::acc_type            m_load_ff [N];
   gemm_pkg::acc_type            m_load_in [N];

   // Accumulators and the snapshot of a finished tile.
   gemm_pkg::acc_type            acc_ff  [N][N];
   gemm_pkg::acc_type            acc_in  [N][N];
   gemm_pkg::acc_type            snap_ff [N][N];
   gemm_pkg::acc_type            snap_in [N][N];
   logic                         busy_ff, busy_in;
   logic [gemm_pkg::ROW_W-1:0]   cnt_ff, cnt_in;

   logic signed [gemm_pkg::DATA_W-1:0] a_op [N];
   logic signed [gemm_pkg::DATA_W-1:0] b_op [N];
   logic                         stall;
   logic                         advance;
   logic                         rsp_fire;

   // A closing step waits while the previous tile is still being emitted.
   assign stall    = m_valid_ff && (m_op_ff == gemm_pkg::OP_ACC_LAST) && busy_ff;
   assign advance  = m_valid_ff && !stall;
   assign pop      = queue_not_empty && (!m_valid_ff || advance);
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         a_op[i]      = $signed(queue_item.x[i][gemm_pkg::DATA_W-1:0]);
         b_op[i]      = gemm_pkg::DATA_W'($signed(queue_item.b[i]));
         m_load_in[i] = gemm_pkg::clamp_acc(
                           gemm_pkg::WIDE_W'($signed(queue_item.x[i])));
      end
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            m_prod_in[i][j] = a_op[i] * b_op[j];
         end
      end
      m_op_in  = queue_item.op;
      m_row_in = queue_item.row;
      if (pop) begin
         m_valid_in = 1'b1;
      end else if (advance) begin
         m_valid_in = 1'b0;
      end else begin
         m_valid_in = m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_op_ff   <= m_op_in;
         m_row_ff  <= m_row_in;
         m_prod_ff <= m_prod_in;
         m_load_ff <= m_load_in;
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      snap_in = snap_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (rsp_fire) begin
         cnt_in = cnt_ff + gemm_pkg::ROW_W'(1);
         if (cnt_ff == gemm_pkg::ROW_W'(N - 1)) begin
            busy_in = 1'b0;
         end
      end
      if (advance) begin
         unique case (m_op_ff)
            gemm_pkg::OP_LOAD: begin
               for (int j = 0; j < N; j++) begin
                  acc_in[m_row_ff][j] = m_load_ff[j];
               end
            end
            gemm_pkg::OP_ACC, gemm_pkg::OP_ACC_LAST: begin
               for (int i = 0; i < N; i++) begin
                  for (int j = 0; j < N; j++) begin
                     acc_in[i][j] = gemm_pkg::clamp_acc(
                        gemm_pkg::WIDE_W'(acc_ff[i][j]) +
                        gemm_pkg::WIDE_W'(m_prod_ff[i][j]));
                  end
               end
               // The finished tile moves to the snapshot and the accumulators restart.
               if (m_op_ff == gemm_pkg::OP_ACC_LAST) begin
                  snap_in = acc_in;
                  for (int i = 0; i < N; i++) begin
                     for (int j = 0; j < N; j++) begin
                        acc_in[i][j] = '0;
                     end
                  end
                  busy_in = 1'b1;
                  cnt_in  = '0;
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
               acc_ff[i][j] <= '0;
            end
         end
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign rsp_ch.valid    = busy_ff;
   assign rsp_ch.out_row  = cnt_ff;
   assign rsp_ch.sum0     = gemm_pkg::clamp_field(gemm_pkg::WIDE_W'(snap_ff[cnt_ff][0]));
   assign rsp_ch.sum1     = gemm_pkg::clamp_field(gemm_pkg::WIDE_W'(snap_ff[cnt_ff][1]));
   assign rsp_ch.sum2     = gemm_pkg::clamp_field(gemm_pkg::WIDE_W'(snap_ff[cnt_ff][2]));
   assign rsp_ch.sum3     = gemm_pkg::clamp_field(gemm_pkg::WIDE_W'(snap_ff[cnt_ff][3]));
   assign rsp_ch.last_row = (cnt_ff == gemm_pkg::ROW_W'(N - 1));

`ifndef SYNTHESIS
   a_emit_starts_at_row0: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == '0)
      else $error("tile emission did not start at row 0");
   a_emit_follows_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(advance && m_op_ff == gemm_pkg::OP_ACC_LAST))
      else $error("tile emission without a closing step");
   a_emit_ends_after_row3: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_ch.last_row |=> !busy_ff)
      else $error("emitter still busy after the last row");
   a_no_close_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && m_valid_ff && m_op_ff == gemm_pkg::OP_ACC_LAST |-> !advance)
      else $error("tile closed while previous tile still pending");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/gemm_4x4_tile_accumulator_core.sv -----
// Top level of the 4x4 fixed-point tile accumulator.
// Words on req_ch enter a two-entry queue at one per cycle when not full, pass a multiply
// stage (sixteen DATA_W by DATA_W products in parallel) and a saturating accumulate stage;
// load and accumulate words run at one per cycle unless a closing word stalls. An accumulate
// word with last_k set copies the finished tile into a snapshot and clears the accumulators;
// the four rows then leave on rsp_ch, row 0 first, one per handshake. The snapshot holds one
// tile, so a further closing word waits in the multiply stage until all four rows of the
// previous tile have been taken. Accumulators are Q18.30 and saturate on every addition.
`default_nettype none
module gemm_4x4_tile_accumulator_core (
   input  wire logic  clock,
   input  wire logic  reset,
   gemm_req_if.sink   req_ch,
   gemm_rsp_if.source rsp_ch
);

   logic               queue_full;
   logic               queue_not_empty;
   logic               push;
   logic               pop;
   gemm_pkg::item_type push_item;
   gemm_pkg::item_type queue_item;

   gemm_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   gemm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (queue_item)
   );

   gemm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_item      (queue_item),
      .pop             (pop),
      .rsp_ch          (rsp_ch)
   );

endmodule
`default_nettype wire

// ----- tb/tb_gemm_4x4_tile_accumulator_core.sv -----
// Self-checking testbench for the 4x4 fixed-point tile accumulator core.
`timescale 1ns / 100ps
module tb_gemm_4x4_tile_accumulator_core;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 10;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_CAP   = 10;
   localparam int RANDOM_WORDS = 330;

   typedef logic signed [71:0] wide_type;

   typedef struct packed {
      logic                                          command;
      logic [gemm_pkg::ROW_W-1:0]                    row;
      gemm_pkg::field_type [gemm_pkg::TILE_N-1:0]    x;
      gemm_pkg::bval_type [gemm_pkg::TILE_N-1:0]     b;
      logic                                          last_k;
   } req_word_type;

   typedef struct packed {
      logic [gemm_pkg::ROW_W-1:0]                    out_row;
      gemm_pkg::field_type [gemm_pkg::TILE_N-1:0]    sums;
      logic                                          last_row;
   } tile_row_type;

   localparam gemm_pkg::field_type FIELD_TOP    = {1'b0, {(gemm_pkg::FIELD_W - 1){1'b1}}};
   localparam gemm_pkg::field_type FIELD_BOTTOM = ~FIELD_TOP;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gemm_req_if req_ch ();
   gemm_rsp_if rsp_ch ();

   gemm_4x4_tile_accumulator_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gemm_pkg::acc_type tile_acc [gemm_pkg::TILE_N][gemm_pkg::TILE_N];
   tile_row_type      expected_rows [$];
   bit                send_steady;
   bit                take_steady;
   int                mismatches;
   int                words_sent;
   int                loads_sent;
   int                steps_sent;
   int                tiles_closed;
   int                rows_checked;
   int                saturations;
   int                quiet_cycles;

   always #CLK_HALF clock = ~clock;

   function automatic wide_type clamp_to(input wide_type v, input int w);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   task automatic clear_tile();
      for (int i = 0; i < gemm_pkg::TILE_N; i++) begin
         for (int j = 0; j < gemm_pkg::TILE_N; j++) begin
            tile_acc[i][j] = '0;
         end
      end
   endtask

   // Updates the accumulator copy for one accepted word and queues the rows it releases.
   task automatic predict_word(input req_word_type w);
      logic signed [gemm_pkg::DATA_W-1:0] a_op [gemm_pkg::TILE_N];
      logic signed [gemm_pkg::DATA_W-1:0] b_op [gemm_pkg::TILE_N];
      wide_type                           b_ext;
      wide_type                           sum;
      wide_type                           kept;
      tile_row_type                       row_exp;
      if (w.command == gemm_pkg::CMD_LOAD) begin
         for (int j = 0; j < gemm_pkg::TILE_N; j++) begin
            kept = clamp_to(wide_type'($signed(w.x[j])), gemm_pkg::ACC_W);
            tile_acc[w.row][j] = gemm_pkg::acc_type'(kept);
         end
      end else begin
         // A uses only its low DATA_W bits; B is widened from 16 bits and then cut the same way.
         for (int i = 0; i < gemm_pkg::TILE_N; i++) begin
            a_op[i] = w.x[i][gemm_pkg::DATA_W-1:0];
            b_ext = wide_type'($signed(w.b[i]));
            b_op[i] = b_ext[gemm_pkg::DATA_W-1:0];
         end
         for (int i = 0; i < gemm_pkg::TILE_N; i++) begin
            for (int j = 0; j < gemm_pkg::TILE_N; j++) begin
               sum = wide_type'(tile_acc[i][j]) + wide_type'(a_op[i]) * wide_type'(b_op[j]);
               kept = clamp_to(sum, gemm_pkg::ACC_W);
               if (kept != sum) saturations++;
               tile_acc[i][j] = gemm_pkg::acc_type'(kept);
            end
         end
         if (w.last_k) begin
            for (int i = 0; i < gemm_pkg::TILE_N; i++) begin
               row_exp.out_row = gemm_pkg::ROW_W'(i);
               for (int j = 0; j < gemm_pkg::TILE_N; j++) begin
                  kept = clamp_to(wide_type'(tile_acc[i][j]), gemm_pkg::FIELD_W);
                  row_exp.sums[j] = gemm_pkg::field_type'(kept);
               end
               row_exp.last_row = (i == gemm_pkg::TILE_N - 1);
               expected_rows.push_back(row_exp);
            end
            clear_tile();
            tiles_closed++;
         end
      end
   endtask

   task automatic send_word(input req_word_type w);
      int unsigned gap;
      gap = send_steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= w.command;
      req_ch.row     <= w.row;
      req_ch.x0      <= w.x[0];
      req_ch.x1      <= w.x[1];
      req_ch.x2      <= w.x[2];
      req_ch.x3      <= w.x[3];
      req_ch.b0      <= w.b[0];
      req_ch.b1      <= w.b[1];
      req_ch.b2      <= w.b[2];
      req_ch.b3      <= w.b[3];
      req_ch.last_k  <= w.last_k;
      do @(posedge clock); while (!req_ch.ready);
      predict_word(w);
      words_sent++;
      if (w.command == gemm_pkg::CMD_LOAD) loads_sent++;
      else steps_sent++;
   endtask

   function automatic req_word_type load_word(input logic [gemm_pkg::ROW_W-1:0] r,
                                              input gemm_pkg::field_type c0, c1, c2, c3);
      req_word_type w;
      w = '0;
      w.command = gemm_pkg::CMD_LOAD;
      w.row = r;
      w.x = {c3, c2, c1, c0};
      return w;
   endfunction

   function automatic req_word_type step_word(input gemm_pkg::field_type a0, a1, a2, a3,
                                              input gemm_pkg::bval_type b0, b1, b2, b3,
                                              input logic close_tile);
      req_word_type w;
      w.command = gemm_pkg::CMD_ACCUMULATE;
      w.row = gemm_pkg::ROW_W'($urandom);
      w.x = {a3, a2, a1, a0};
      w.b = {b3, b2, b1, b0};
      w.last_k = close_tile;
      return w;
   endfunction

   function automatic gemm_pkg::field_type rand_wide();
      return gemm_pkg::field_type'({$urandom, $urandom});
   endfunction

   function automatic gemm_pkg::bval_type rand_b();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return gemm_pkg::bval_type'($urandom);
      endcase
   endfunction

   function automatic gemm_pkg::field_type rand_a();
      gemm_pkg::bval_type s;
      s = rand_b();
      // Now and then the whole 48-bit word is random, so the ignored upper bits toggle.
      if ($urandom_range(0, 7) == 0) return rand_wide();
      return gemm_pkg::field_type'(s);
   endfunction

   function automatic gemm_pkg::field_type rand_load_value();
      logic signed [35:0] v;
      v = 36'({$urandom, $urandom});
      case ($urandom_range(0, 5))
         0: return rand_wide();
         1: return FIELD_TOP - gemm_pkg::field_type'($urandom);
         2: return FIELD_BOTTOM + gemm_pkg::field_type'($urandom);
         default: return gemm_pkg::field_type'(v);
      endcase
   endfunction

   function automatic req_word_type rand_step(input logic close_tile);
      return step_word(rand_a(), rand_a(), rand_a(), rand_a(),
                       rand_b(), rand_b(), rand_b(), rand_b(), close_tile);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic check_row(input tile_row_type want, input tile_row_type got);
      if (got.out_row != want.out_row) begin
         note_mismatch($sformatf("out_row: expected %0d, got %0d", want.out_row, got.out_row));
      end
      for (int j = 0; j < gemm_pkg::TILE_N; j++) begin
         if (got.sums[j] != want.sums[j]) begin
            note_mismatch($sformatf("row %0d sum%0d: expected %0d, got %0d", want.out_row, j,
                                    $signed(want.sums[j]), $signed(got.sums[j])));
         end
      end
      if (got.last_row != want.last_row) begin
         note_mismatch($sformatf("row %0d last_row: expected %0b, got %0b", want.out_row,
                                 want.last_row, got.last_row));
      end
   endtask

   // Result side: random back-pressure, then each row word is checked against the oldest one due.
   initial begin
      tile_row_type got;
      int unsigned  stall;
      rsp_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = take_steady ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.out_row  = rsp_ch.out_row;
         got.sums     = {rsp_ch.sum3, rsp_ch.sum2, rsp_ch.sum1, rsp_ch.sum0};
         got.last_row = rsp_ch.last_row;
         rows_checked++;
         if (expected_rows.size() == 0) begin
            note_mismatch($sformatf("tile row %0d arrived with nothing expected", got.out_row));
         end else begin
            check_row(expected_rows.pop_front(), got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles, %0d rows still due",
                  quiet_cycles, expected_rows.size());
         $display("** gemm_4x4_tile_accumulator_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Loads of every row with the field extremes, an overwrite, a load carrying B and last_k, and a closing step.
   task automatic test_load_rows();
      req_word_type w;
      send_word(load_word(0, FIELD_TOP, FIELD_BOTTOM, 0, -1));
      w = load_word(1, 1, 2, 3, 4);
      w.b = {16'sh7fff, 16'sh8000, 16'shffff, 16'sh5a5a};
      w.last_k = 1'b1;
      send_word(w);
      send_word(load_word(1, FIELD_BOTTOM, FIELD_TOP, 48'sh5555_5555_5555,
                          48'shaaaa_aaaa_aaaa));
      send_word(load_word(2, -48'sd12345678901, 48'sd98765432109, 48'sd1073741824,
                          -48'sd1073741824));
      send_word(load_word(3, 48'sh0000_8000_0000, 48'sh7fff_0000_ffff, -48'sd32768,
                          48'sd32767));
      send_word(step_word(0, 0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 1'b1));
   endtask

   task automatic test_operand_extremes();
      send_word(step_word(32767, -32768, -1, 0, -32768, 32767, 1, -1, 1'b0));
      // Only the low 16 bits of each A value count; the upper bits are noise.
      send_word(step_word(48'sh7fff_ffff_8000, 48'sh8000_0000_7fff, 48'shffff_0000_0001,
                          48'sh0123_4567_ffff, 32767, -32768, -32768, 32767, 1'b0));
      send_word(step_word(-32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, 1'b1));
   endtask

   task automatic test_saturation();
      send_word(load_word(0, FIELD_TOP - 1000, FIELD_TOP - 1000, FIELD_TOP - 1000,
                          FIELD_TOP - 1000));
      send_word(load_word(3, FIELD_BOTTOM + 1000, FIELD_BOTTOM + 1000, FIELD_BOTTOM + 1000,
                          FIELD_BOTTOM + 1000));
      send_word(step_word(32767, 0, 0, -32768, 32767, 32767, 32767, 32767, 1'b0));
      // Row 0 stays pinned at the top in column 0 and comes back down in column 1.
      send_word(step_word(-32768, 0, 0, -32768, -32768, 32767, 1, -1, 1'b0));
      send_word(step_word(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      send_word(load_word(1, FIELD_BOTTOM, FIELD_BOTTOM, FIELD_BOTTOM, FIELD_BOTTOM));
      send_word(step_word(0, -32768, 0, 0, 32767, 32767, 32767, 32767, 1'b1));
   endtask

   // Closing words back to back while the result side stalls, so each one waits for the last tile.
   task automatic test_closing_back_to_back();
      send_steady = 1'b1;
      take_steady = 1'b0;
      repeat (4) send_word(rand_step(1'b1));
      send_steady = 1'b0;
   endtask

   // Mostly well-formed tiles (some row loads, then k steps ending on last_k), some noise.
   task automatic test_random_tiles(input int n_words);
      req_word_type w;
      int           target;
      int           n_loads;
      int           n_steps;
      target = words_sent + n_words;
      while (words_sent < target) begin
         send_steady = ($urandom_range(0, 4) == 0);
         take_steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            w.command = 1'($urandom);
            w.row     = gemm_pkg::ROW_W'($urandom);
            for (int j = 0; j < gemm_pkg::TILE_N; j++) begin
               w.x[j] = rand_wide();
               w.b[j] = rand_b();
            end
            w.last_k = ($urandom_range(0, 3) == 0);
            send_word(w);
         end else begin
            n_loads = $urandom_range(0, gemm_pkg::TILE_N);
            n_steps = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            repeat (n_loads) begin
               w = load_word(gemm_pkg::ROW_W'($urandom), rand_load_value(), rand_load_value(),
                             rand_load_value(), rand_load_value());
               w.b = {rand_b(), rand_b(), rand_b(), rand_b()};
               w.last_k = 1'($urandom);
               send_word(w);
            end
            for (int k = 0; k < n_steps; k++) begin
               send_word(rand_step(k == n_steps - 1));
            end
         end
      end
      send_steady = 1'b0;
      take_steady = 1'b0;
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.command <= gemm_pkg::CMD_LOAD;
      req_ch.row     <= '0;
      req_ch.x0      <= '0;
      req_ch.x1      <= '0;
      req_ch.x2      <= '0;
      req_ch.x3      <= '0;
      req_ch.b0      <= '0;
      req_ch.b1      <= '0;
      req_ch.b2      <= '0;
      req_ch.b3      <= '0;
      req_ch.last_k  <= 1'b0;
      send_steady = 1'b0;
      take_steady = 1'b0;
      clear_tile();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_load_rows();
      test_operand_extremes();
      test_saturation();
      test_closing_back_to_back();
      test_random_tiles(RANDOM_WORDS);

      req_ch.valid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request words: %0d row loads and %0d k steps, closing %0d tiles.",
               words_sent, loads_sent, steps_sent, tiles_closed);
      $display("%0d tile rows compared, %0d saturating updates predicted, %0d mismatches.",
               rows_checked, saturations, mismatches);
      if (mismatches == 0) begin
         $display("** gemm_4x4_tile_accumulator_core: PASSED **");
      end else begin
         $display("** gemm_4x4_tile_accumulator_core: FAILED **");
      end
      $finish;
   end

endmodule
